// ----- sv/dccc_pkg.sv -----
// shared constants and types for the distance cutoff contact counter
package dccc_pkg;

  localparam int MAX_TARGET_ATOMS = 4096;
  localparam int MAX_RESIDUES     = 1024;
  localparam int COORD_BITS       = 24;

  localparam int CMD_W    = 2;
  localparam int SLOT_W   = 12;
  localparam int RESNUM_W = 10;
  localparam int COUNT_W  = 32;
  localparam int CUTOFF_W = 50;
  localparam int TCNT_W   = 13;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 64;

  localparam int ATOM_AW = $clog2(MAX_TARGET_ATOMS);
  localparam int RES_AW  = $clog2(MAX_RESIDUES);
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int MAG_W   = COORD_BITS;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int ACC_W   = SQ_W + 2;
  localparam int TREC_W  = RESNUM_W + 3 * COORD_BITS;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD     = 2'd0,
    CMD_STREAM   = 2'd1,
    CMD_READ_ATM = 2'd2,
    CMD_READ_RES = 2'd3
  } cmd_t;

  // register index, taken from paddr bit 3 (registers sit 8 bytes apart)
  typedef enum logic {
    REG_CUTOFF = 1'b0,
    REG_TCOUNT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RESP,
    ST_FETCH,
    ST_DIFF,
    ST_MUL,
    ST_CMP,
    ST_BUMP
  } state_t;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_t;

  // control of one counter memory
  typedef struct packed {
    logic               we;
    logic [ATOM_AW-1:0] waddr;
    logic               re;
    logic [ATOM_AW-1:0] raddr;
  } cnt_ctl_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == {COUNT_W{1'b1}}) ? v : v + COUNT_W'(1);
  endfunction

endpackage

// ----- sv/dccc_ram.sv -----
// generic single write port, single read port ram with registered read
module dccc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/distance_cutoff_contact_counter.sv -----
// top level: target table, shared distance unit and saturating contact counters
//
//   channel   handshake               payload
//   input     start / busy            in_command, in_slot, in_pos_x/y/z, in_residue
//   result    out_valid (one cycle)   out_count
//   config    apb psel/penable/pready paddr (reg at 8*i), pwdata, prdata
//
// a load writes the target table on accept; a count read returns its result from ST_RESP
// a group atom runs FETCH, then DIFF and MUL per axis, then CMP (and BUMP on contact) for each
// of n = min(tcount, 4096) targets, with one subtract/abs unit and one 24x24 multiplier used once per axis
// after reset ST_CLEAR walks all 4096 slots zeroing both counter memories, busy stays high
// results cannot be stalled; out_valid is high for exactly one cycle
module distance_cutoff_contact_counter (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [dccc_pkg::CMD_W-1:0]            in_command,
  input  logic [dccc_pkg::SLOT_W-1:0]           in_slot,
  input  logic signed [dccc_pkg::COORD_BITS-1:0] in_pos_x,
  input  logic signed [dccc_pkg::COORD_BITS-1:0] in_pos_y,
  input  logic signed [dccc_pkg::COORD_BITS-1:0] in_pos_z,
  input  logic [dccc_pkg::RESNUM_W-1:0]         in_residue,
  output logic                                  out_valid,
  output logic [dccc_pkg::COUNT_W-1:0]          out_count,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [dccc_pkg::APB_AW-1:0]           paddr,
  input  logic [dccc_pkg::APB_DW-1:0]           pwdata,
  output logic [dccc_pkg::APB_DW-1:0]           prdata,
  output logic                                  pready
);

  import dccc_pkg::*;

  state_t state_r, state_nxt;

  logic [CUTOFF_W-1:0]   cutoff_r;
  logic [TCNT_W-1:0]     tcount_r;
  logic [ATOM_AW-1:0]    clr_r, clr_nxt;
  logic [ATOM_AW-1:0]    idx_r, idx_nxt;
  axis_t                 axis_r, axis_nxt;
  logic [MAG_W-1:0]      mag_r, mag_nxt;
  logic [ACC_W-1:0]      acc_r, acc_nxt;
  logic [COORD_BITS-1:0] gx_r, gy_r, gz_r;
  logic                  resp_res_r, resp_zero_r;

  logic                  accept;
  cmd_t                  cmd;
  logic                  cfg_wr;
  logic [TCNT_W-1:0]     n_eff;
  logic                  last_atom;
  logic                  contact;

  // target table
  logic                  trec_we, trec_re;
  logic [TREC_W-1:0]     trec_wdata, trec_rdata;
  logic [COORD_BITS-1:0] t_x, t_y, t_z, t_sel, g_sel;
  logic [RESNUM_W-1:0]   t_res;
  logic                  t_res_ok;
  logic signed [DIFF_W-1:0] diff;

  // counters
  cnt_ctl_t              atm_ctl, res_ctl;
  logic [COUNT_W-1:0]    atm_wdata, res_wdata, atm_rdata, res_rdata;

  assign accept = start && !busy;
  assign cmd    = cmd_t'(in_command);
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (reg_idx_t'(paddr[3]) == REG_TCOUNT) ? APB_DW'(tcount_r) : APB_DW'(cutoff_r);

  assign n_eff = (32'(tcount_r) > 32'(MAX_TARGET_ATOMS)) ?
                 TCNT_W'(MAX_TARGET_ATOMS) : tcount_r;
  assign last_atom = ({1'b0, idx_r} + TCNT_W'(1)) == n_eff;

  assign t_x      = trec_rdata[COORD_BITS-1:0];
  assign t_y      = trec_rdata[2*COORD_BITS-1:COORD_BITS];
  assign t_z      = trec_rdata[3*COORD_BITS-1:2*COORD_BITS];
  assign t_res    = trec_rdata[TREC_W-1:3*COORD_BITS];
  assign t_res_ok = 32'(t_res) < 32'(MAX_RESIDUES);
  assign contact  = acc_r < ACC_W'(cutoff_r);

  assign trec_wdata = {in_residue, in_pos_z, in_pos_y, in_pos_x};

  always_comb begin
    case (axis_r)
      AX_X:    begin t_sel = t_x; g_sel = gx_r; end
      AX_Y:    begin t_sel = t_y; g_sel = gy_r; end
      AX_Z:    begin t_sel = t_z; g_sel = gz_r; end
      default: begin t_sel = t_x; g_sel = gx_r; end
    endcase
  end

  // shared distance unit: |t - g| then square and accumulate
  assign diff    = $signed({t_sel[COORD_BITS-1], t_sel}) - $signed({g_sel[COORD_BITS-1], g_sel});
  assign mag_nxt = diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
  assign acc_nxt = ((axis_r == AX_X) ? '0 : acc_r) + ACC_W'(mag_r * mag_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == ATOM_AW'(MAX_TARGET_ATOMS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_LOAD:     state_nxt = ST_IDLE;
            CMD_STREAM:   state_nxt = (n_eff == '0) ? ST_IDLE : ST_FETCH;
            CMD_READ_ATM: state_nxt = ST_RESP;
            CMD_READ_RES: state_nxt = ST_RESP;
            default:      state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RESP:  state_nxt = ST_IDLE;
      ST_FETCH: state_nxt = ST_DIFF;
      ST_DIFF:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = (axis_r == AX_Z) ? ST_CMP : ST_DIFF;
      ST_CMP: begin
        if (contact)        state_nxt = ST_BUMP;
        else if (last_atom) state_nxt = ST_IDLE;
        else                state_nxt = ST_FETCH;
      end
      ST_BUMP:  state_nxt = last_atom ? ST_IDLE : ST_FETCH;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    busy      = 1'b1;
    out_valid = 1'b0;
    trec_we   = 1'b0;
    trec_re   = 1'b0;
    atm_ctl   = '{we: 1'b0, waddr: idx_r, re: 1'b0, raddr: idx_r};
    res_ctl   = '{we: 1'b0, waddr: ATOM_AW'(t_res), re: 1'b0, raddr: ATOM_AW'(t_res)};
    atm_wdata = sat_inc(atm_rdata);
    res_wdata = sat_inc(res_rdata);
    case (state_r)
      ST_CLEAR: begin
        atm_ctl.we    = 1'b1;
        atm_ctl.waddr = clr_r;
        res_ctl.we    = 1'b1;
        res_ctl.waddr = clr_r;
        atm_wdata     = '0;
        res_wdata     = '0;
      end
      ST_IDLE: begin
        busy          = 1'b0;
        trec_we       = accept && (cmd == CMD_LOAD) &&
                        (32'(in_slot) < 32'(MAX_TARGET_ATOMS));
        atm_ctl.re    = accept && (cmd == CMD_READ_ATM);
        atm_ctl.raddr = ATOM_AW'(in_slot);
        res_ctl.re    = accept && (cmd == CMD_READ_RES);
        res_ctl.raddr = ATOM_AW'(in_slot);
      end
      ST_RESP:  out_valid = 1'b1;
      ST_FETCH: trec_re = 1'b1;
      ST_CMP: begin
        atm_ctl.re = contact;
        res_ctl.re = contact && t_res_ok;
      end
      ST_BUMP: begin
        atm_ctl.we = 1'b1;
        res_ctl.we = t_res_ok;
      end
      default: ;
    endcase
  end

  assign out_count = resp_zero_r ? '0 : (resp_res_r ? res_rdata : atm_rdata);

  // sequencer counters
  always_comb begin
    clr_nxt  = clr_r;
    idx_nxt  = idx_r;
    axis_nxt = axis_r;
    case (state_r)
      ST_CLEAR: clr_nxt = clr_r + ATOM_AW'(1);
      ST_IDLE: begin
        idx_nxt  = '0;
        axis_nxt = AX_X;
      end
      ST_MUL: begin
        case (axis_r)
          AX_X:    axis_nxt = AX_Y;
          AX_Y:    axis_nxt = AX_Z;
          default: axis_nxt = AX_X;
        endcase
      end
      ST_CMP:  if (!contact) idx_nxt = idx_r + ATOM_AW'(1);
      ST_BUMP: idx_nxt = idx_r + ATOM_AW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      clr_r    <= '0;
      idx_r    <= '0;
      axis_r   <= AX_X;
      cutoff_r <= '0;
      tcount_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      idx_r   <= idx_nxt;
      axis_r  <= axis_nxt;
      if (cfg_wr) begin
        if (reg_idx_t'(paddr[3]) == REG_TCOUNT) tcount_r <= pwdata[TCNT_W-1:0];
        else                                     cutoff_r <= pwdata[CUTOFF_W-1:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == ST_DIFF) mag_r <= mag_nxt;
    if (state_r == ST_MUL)  acc_r <= acc_nxt;
    if (accept) begin
      gx_r        <= in_pos_x;
      gy_r        <= in_pos_y;
      gz_r        <= in_pos_z;
      resp_res_r  <= (cmd == CMD_READ_RES);
      resp_zero_r <= (cmd == CMD_READ_RES) ? (32'(in_slot) >= 32'(MAX_RESIDUES)) :
                                             (32'(in_slot) >= 32'(MAX_TARGET_ATOMS));
    end
  end

  dccc_ram #(.WIDTH(TREC_W), .DEPTH(MAX_TARGET_ATOMS)) u_trec_ram (
    .clk   (clk),
    .we    (trec_we),
    .waddr (ATOM_AW'(in_slot)),
    .wdata (trec_wdata),
    .re    (trec_re),
    .raddr (idx_r),
    .rdata (trec_rdata)
  );

  dccc_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_TARGET_ATOMS)) u_atm_ram (
    .clk   (clk),
    .we    (atm_ctl.we),
    .waddr (atm_ctl.waddr),
    .wdata (atm_wdata),
    .re    (atm_ctl.re),
    .raddr (atm_ctl.raddr),
    .rdata (atm_rdata)
  );

  dccc_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_RESIDUES)) u_res_ram (
    .clk   (clk),
    .we    (res_ctl.we),
    .waddr (res_ctl.waddr[RES_AW-1:0]),
    .wdata (res_wdata),
    .re    (res_ctl.re),
    .raddr (res_ctl.raddr[RES_AW-1:0]),
    .rdata (res_rdata)
  );

  // a read item gives its result in the very next cycle
  a_read_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (cmd == CMD_READ_ATM || cmd == CMD_READ_RES)) |=> out_valid)
    else $error("read item without result");

  // load and stream items never produce a result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (cmd == CMD_LOAD || cmd == CMD_STREAM)) |=> !out_valid)
    else $error("result without read item");

  // result strobe lasts one cycle and only while busy
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy ##1 !out_valid)
    else $error("result strobe malformed");

  // counter memories are only written during clearing or a contact bump
  a_cnt_write: assert property (@(posedge clk) disable iff (!rst_n)
    atm_ctl.we |-> (state_r == ST_CLEAR || state_r == ST_BUMP))
    else $error("unexpected counter write");

endmodule
